// ----- design/cfsm_pkg.sv -----
// Shared types, character codes and helpers for the cron field spec matcher.
// Used by cfsm_ctrl, cfsm_dpath and the top level; depends on nothing.
package cfsm_pkg;

  localparam int unsigned NumW   = 10;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DivCntW = 3;

  localparam logic [NumW-1:0]    NumMax  = 10'd1023;
  localparam logic [DivCntW-1:0] DivLast = 3'd7;

  localparam logic [ByteW-1:0] ChComma = 8'h2c;
  localparam logic [ByteW-1:0] ChSlash = 8'h2f;
  localparam logic [ByteW-1:0] ChStar  = 8'h2a;
  localparam logic [ByteW-1:0] ChDash  = 8'h2d;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  typedef enum logic [1:0] {
    PH_LOWER      = 2'd0,
    PH_UPPER      = 2'd1,
    PH_STEP_ONE   = 2'd2,
    PH_STEP_RANGE = 2'd3
  } cfsm_phase_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_DIV  = 2'd2,
    ST_DONE = 2'd3
  } cfsm_state_e;

  typedef struct packed {
    logic take;      // input transfer this cycle
    logic eval;      // judge the closed item, load the divider
    logic div_step;  // one remainder iteration
    logic commit;    // fold the item into the spec result, clear the item
    logic emit;      // load the result register, clear the spec
  } cfsm_cmd_t;

  typedef struct packed {
    logic closes;    // incoming character closes an item
    logic need_div;  // item passes bound checks and carries a step
    logic div_last;  // final remainder iteration
    logic spec_end;  // closed item was the last of the spec
    logic out_free;  // result register can take a new value
  } cfsm_sts_t;

  // Decimal accumulate, saturating at the largest number.
  function automatic logic [NumW-1:0] acc10(logic [NumW-1:0] acc, logic [3:0] dig);
    logic [NumW+3:0] v;
    v = {acc, 3'b000} + {3'b000, acc, 1'b0} + {{NumW{1'b0}}, dig};
    acc10 = (v > {4'b0000, NumMax}) ? NumMax : v[NumW-1:0];
  endfunction

endpackage

// ----- design/cfsm_ctrl.sv -----
// Sequencing state machine for the cron field spec matcher.
// Depends on cfsm_pkg; drives commands into cfsm_dpath and reads its status.
module cfsm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cfsm_pkg::cfsm_sts_t sts_i,
  output cfsm_pkg::cfsm_cmd_t cmd_o
);

  cfsm_pkg::cfsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfsm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      cfsm_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.closes) begin
            state_d = cfsm_pkg::ST_EVAL;
          end
        end
      end
      cfsm_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.need_div ? cfsm_pkg::ST_DIV : cfsm_pkg::ST_DONE;
      end
      cfsm_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = cfsm_pkg::ST_DONE;
        end
      end
      cfsm_pkg::ST_DONE: begin
        // end of spec waits here until the result register is free
        if (!sts_i.spec_end) begin
          cmd_o.commit = 1'b1;
          state_d      = cfsm_pkg::ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          cmd_o.emit   = 1'b1;
          state_d      = cfsm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cfsm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/cfsm_dpath.sv -----
// Datapath of the cron field spec matcher: item parser, bound checks,
// bit-serial remainder unit and result register. Depends on cfsm_pkg.
module cfsm_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfsm_pkg::cfsm_cmd_t cmd_i,
  output cfsm_pkg::cfsm_sts_t sts_o,
  input  logic [7:0]          spec_char_i,
  input  logic                char_present_i,
  input  logic                end_of_spec_i,
  input  logic [7:0]          field_value_i,
  input  logic [7:0]          range_low_i,
  input  logic [7:0]          range_high_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                matched_o
);

  // item parser state
  cfsm_pkg::cfsm_phase_e phase_q, phase_d;
  logic [9:0] lower_q, lower_d, upper_q, upper_d, step_q, step_d;
  logic       lower_has_q, lower_has_d, upper_has_q, upper_has_d;
  logic       step_has_q, step_has_d;
  logic [1:0] head_len_q, head_len_d;
  logic       star_q, star_d, invalid_q, invalid_d;

  // operands sampled on every input transfer; the closing transfer's values are judged
  logic [7:0] val_q, lo_q, hi_q;
  logic       last_q, match_seen_q, hit_q;

  // remainder unit
  logic [9:0] rem_q;
  logic [7:0] dvd_q;
  logic [2:0] cnt_q;

  logic       out_valid_q, matched_q;

  logic       is_digit, take_char;
  logic [3:0] dig;

  assign is_digit  = (spec_char_i >= cfsm_pkg::ChZero) && (spec_char_i <= cfsm_pkg::ChNine);
  assign dig       = 4'(spec_char_i - cfsm_pkg::ChZero);
  assign take_char = cmd_i.take && char_present_i && (spec_char_i != cfsm_pkg::ChComma);

  always_comb begin
    phase_d     = phase_q;
    lower_d     = lower_q;
    upper_d     = upper_q;
    step_d      = step_q;
    lower_has_d = lower_has_q;
    upper_has_d = upper_has_q;
    step_has_d  = step_has_q;
    head_len_d  = head_len_q;
    star_d      = star_q;
    invalid_d   = invalid_q;
    if (cmd_i.commit) begin
      phase_d     = cfsm_pkg::PH_LOWER;
      lower_d     = '0;
      upper_d     = '0;
      step_d      = '0;
      lower_has_d = 1'b0;
      upper_has_d = 1'b0;
      step_has_d  = 1'b0;
      head_len_d  = '0;
      star_d      = 1'b0;
      invalid_d   = 1'b0;
    end else if (take_char) begin
      if (phase_q == cfsm_pkg::PH_STEP_ONE || phase_q == cfsm_pkg::PH_STEP_RANGE) begin
        if (is_digit) begin
          step_d     = cfsm_pkg::acc10(step_q, dig);
          step_has_d = 1'b1;
        end else begin
          invalid_d = 1'b1;
        end
      end else if (spec_char_i == cfsm_pkg::ChSlash) begin
        phase_d = (phase_q == cfsm_pkg::PH_UPPER) ? cfsm_pkg::PH_STEP_RANGE
                                                  : cfsm_pkg::PH_STEP_ONE;
      end else begin
        if (spec_char_i == cfsm_pkg::ChStar && head_len_q == 2'd0) begin
          star_d = 1'b1;
        end else if (phase_q == cfsm_pkg::PH_LOWER && spec_char_i == cfsm_pkg::ChDash) begin
          phase_d = cfsm_pkg::PH_UPPER;
        end else if (is_digit) begin
          if (phase_q == cfsm_pkg::PH_LOWER) begin
            lower_d     = cfsm_pkg::acc10(lower_q, dig);
            lower_has_d = 1'b1;
          end else begin
            upper_d     = cfsm_pkg::acc10(upper_q, dig);
            upper_has_d = 1'b1;
          end
        end else begin
          invalid_d = 1'b1;
        end
        if (head_len_q != 2'd2) begin
          head_len_d = head_len_q + 2'd1;
        end
      end
    end
  end

  // item judgement on the registered item
  logic       stepped, ranged, bad, pre_ok;
  logic [9:0] first, last, lo_x, hi_x, val_x;
  logic [7:0] diff;

  assign stepped = (phase_q == cfsm_pkg::PH_STEP_ONE) || (phase_q == cfsm_pkg::PH_STEP_RANGE);
  assign ranged  = (phase_q == cfsm_pkg::PH_UPPER) || (phase_q == cfsm_pkg::PH_STEP_RANGE);
  assign lo_x    = {2'b00, lo_q};
  assign hi_x    = {2'b00, hi_q};
  assign val_x   = {2'b00, val_q};

  always_comb begin
    bad   = (head_len_q == 2'd0) || invalid_q;
    first = lower_q;
    last  = lower_q;
    if (stepped && (!step_has_q || step_q == '0)) begin
      bad = 1'b1;
    end
    if (head_len_q == 2'd1 && star_q) begin
      first = lo_x;
      last  = hi_x;
    end else if (star_q) begin
      bad = 1'b1;
    end else if (ranged) begin
      last = upper_q;
      if (!lower_has_q || !upper_has_q) begin
        bad = 1'b1;
      end
    end else if (!lower_has_q) begin
      bad = 1'b1;
    end
  end

  assign pre_ok = !bad && (val_q >= lo_q) && (val_q <= hi_q)
                  && (first >= lo_x) && (last <= hi_x) && (first <= last)
                  && (val_x >= first) && (val_x <= last);
  assign diff   = val_q - first[7:0];

  // restoring remainder, one dividend bit per cycle
  logic [10:0] trial;
  logic [9:0]  rem_next;

  assign trial    = {rem_q, dvd_q[7]};
  assign rem_next = (trial >= {1'b0, step_q}) ? 10'(trial - {1'b0, step_q}) : trial[9:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= cfsm_pkg::PH_LOWER;
      lower_q      <= '0;
      upper_q      <= '0;
      step_q       <= '0;
      lower_has_q  <= 1'b0;
      upper_has_q  <= 1'b0;
      step_has_q   <= 1'b0;
      head_len_q   <= '0;
      star_q       <= 1'b0;
      invalid_q    <= 1'b0;
      last_q       <= 1'b0;
      match_seen_q <= 1'b0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      lower_q     <= lower_d;
      upper_q     <= upper_d;
      step_q      <= step_d;
      lower_has_q <= lower_has_d;
      upper_has_q <= upper_has_d;
      step_has_q  <= step_has_d;
      head_len_q  <= head_len_d;
      star_q      <= star_d;
      invalid_q   <= invalid_d;
      if (cmd_i.take) begin
        last_q <= end_of_spec_i;
      end
      if (cmd_i.eval) begin
        hit_q <= pre_ok;
      end else if (cmd_i.div_step && cnt_q == cfsm_pkg::DivLast) begin
        hit_q <= (rem_next == '0);
      end
      if (cmd_i.emit) begin
        match_seen_q <= 1'b0;
      end else if (cmd_i.commit) begin
        match_seen_q <= match_seen_q | hit_q;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      val_q <= field_value_i;
      lo_q  <= range_low_i;
      hi_q  <= range_high_i;
    end
    if (cmd_i.eval) begin
      rem_q <= '0;
      dvd_q <= diff;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_next;
      dvd_q <= {dvd_q[6:0], 1'b0};
      cnt_q <= cnt_q + 3'd1;
    end
    if (cmd_i.emit) begin
      matched_q <= match_seen_q | hit_q;
    end
  end

  assign sts_o.closes   = end_of_spec_i || (char_present_i && spec_char_i == cfsm_pkg::ChComma);
  assign sts_o.need_div = pre_ok && stepped;
  assign sts_o.div_last = (cnt_q == cfsm_pkg::DivLast);
  assign sts_o.spec_end = last_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

endmodule

// ----- design/cron_field_spec_matcher.sv -----
// channel | direction | payload                                            | handshake
// in      | receive   | spec_char, char_present, end_of_spec, field_value,  | in_valid_i / in_stall_o
//         |           | range_low, range_high                              |
// out     | send      | matched (one per spec, on its last character)      | out_valid_o / out_stall_i
//
// A character that does not close an item is taken while the sequencer stays idle. A ',' or
// the end of the spec goes through transfer, judge and fold; an item with a /step that
// passes its bound checks also runs the bit-serial remainder unit between judge and fold.
// The end of a spec waits in the fold cycle while the result register is still
// full and stalled; input is stalled whenever the sequencer is not idle.
// Reset (rst_ni low, asynchronous) clears the item state and the result valid.
// Top level of the cron field spec matcher. Depends on cfsm_pkg, cfsm_ctrl and cfsm_dpath.
module cron_field_spec_matcher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] spec_char_i,
  input  logic       char_present_i,
  input  logic       end_of_spec_i,
  input  logic [7:0] field_value_i,
  input  logic [7:0] range_low_i,
  input  logic [7:0] range_high_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       matched_o
);

  cfsm_pkg::cfsm_cmd_t cmd;
  cfsm_pkg::cfsm_sts_t sts;

  cfsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cfsm_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .spec_char_i    (spec_char_i),
    .char_present_i (char_present_i),
    .end_of_spec_i  (end_of_spec_i),
    .field_value_i  (field_value_i),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .matched_o      (matched_o)
  );

endmodule

// ----- design/cfsm_checker.sv -----
// Port-level checks for the cron field spec matcher, bound to the top level.
// Depends on the top level's ports and on cfsm_pkg for character codes.
module cfsm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] spec_char_i,
  input logic       char_present_i,
  input logic       end_of_spec_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       matched_o
);

  // a held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(matched_o))
    else $error("stalled result changed");

  // closing the spec always busies the sequencer for the judge cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_spec_i |=> in_stall_o)
    else $error("no judge cycle after end of spec");

  // a plain character within an item leaves the input unstalled in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !end_of_spec_i && char_present_i
      && spec_char_i != cfsm_pkg::ChComma |=> !in_stall_o)
    else $error("character inside item stalled input");

  // a new result only leaves the fold cycle, which frees the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o) && !in_stall_o)
    else $error("result raised outside the fold cycle");

endmodule

bind cron_field_spec_matcher cfsm_checker u_cfsm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .spec_char_i    (spec_char_i),
  .char_present_i (char_present_i),
  .end_of_spec_i  (end_of_spec_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .matched_o      (matched_o)
);
